/* hdl/bwspt_pkg.sv */
// Shared types and constants for the bus wait-state and prefetch timer.
package bwspt_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned PAGE_LSB = 24;
  localparam int unsigned WAIT_W   = 4;
  localparam int unsigned TBL_W    = WAIT_W << PAGE_W;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 8;

  localparam int unsigned OP_SEQ_BIT  = 0;
  localparam int unsigned OP_WIDE_BIT = 1;
  localparam int unsigned OP_CODE_BIT = 2;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [PAGE_W-1:0] PF_PAGE_LO = 4'h2;
  localparam logic [PAGE_W-1:0] PF_PAGE_HI = 4'h7;
  localparam logic [PAGE_W-1:0] GP_PAGE_LO = 4'h8;
  localparam logic [PAGE_W-1:0] GP_PAGE_HI = 4'hD;
  localparam logic [COUNT_W-1:0] LOW_BYTE_MAX = 32'h0000_00FF;

  localparam logic [CFG_IDX_W-1:0] REG_WAIT_NONSEQ16 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_NONSEQ32 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_SEQ16    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_SEQ32    = 8'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               flag;
  } pf_state_t;

  typedef struct packed {
    logic [TBL_W-1:0] nonseq16;
    logic [TBL_W-1:0] nonseq32;
    logic [TBL_W-1:0] seq16;
    logic [TBL_W-1:0] seq32;
  } wait_tbl_t;

endpackage

/* hdl/bwspt_step.sv */
// Per-access wait lookup and prefetch buffer next-state logic.
module bwspt_step (
  input  logic [bwspt_pkg::OP_W-1:0]   op_i,
  input  logic [bwspt_pkg::PAGE_W-1:0] page_i,
  input  logic                         pset_i,
  input  bwspt_pkg::wait_tbl_t         tbl_i,
  input  bwspt_pkg::pf_state_t         state_i,
  output bwspt_pkg::pf_state_t         state_o,
  output logic [bwspt_pkg::WAIT_W-1:0] wait_o
);

  logic                         code, wide, seq, gamepak, flag;
  logic [bwspt_pkg::WAIT_W-1:0] w, w_ns16, w_ns32, w_s16, w_s32, sh;
  logic [bwspt_pkg::COUNT_W-1:0] cnt, drop1, drop2, grown;

  assign code = op_i[bwspt_pkg::OP_CODE_BIT];
  assign wide = op_i[bwspt_pkg::OP_WIDE_BIT];
  assign seq  = op_i[bwspt_pkg::OP_SEQ_BIT];
  assign gamepak = (page_i >= bwspt_pkg::GP_PAGE_LO) && (page_i <= bwspt_pkg::GP_PAGE_HI);
  assign flag = state_i.flag | pset_i;
  assign cnt  = state_i.count;

  assign w_ns16 = tbl_i.nonseq16[page_i*bwspt_pkg::WAIT_W +: bwspt_pkg::WAIT_W];
  assign w_ns32 = tbl_i.nonseq32[page_i*bwspt_pkg::WAIT_W +: bwspt_pkg::WAIT_W];
  assign w_s16  = tbl_i.seq16[page_i*bwspt_pkg::WAIT_W +: bwspt_pkg::WAIT_W];
  assign w_s32  = tbl_i.seq32[page_i*bwspt_pkg::WAIT_W +: bwspt_pkg::WAIT_W];

  assign w  = seq ? (wide ? w_s32 : w_s16) : (wide ? w_ns32 : w_ns16);
  assign sh = (w == '0) ? bwspt_pkg::WAIT_W'(1) : w;

  assign drop1 = {cnt[bwspt_pkg::COUNT_W-1:8], 1'b0, cnt[7:1]};
  assign drop2 = {cnt[bwspt_pkg::COUNT_W-1:8], 2'b00, cnt[7:2]};
  assign grown = ((cnt + bwspt_pkg::COUNT_W'(1)) << sh) - bwspt_pkg::COUNT_W'(1);

  always_comb begin
    state_o.count = cnt;
    state_o.flag  = flag;
    wait_o        = w;
    if (!code) begin
      if (page_i inside {[bwspt_pkg::PF_PAGE_LO:bwspt_pkg::PF_PAGE_HI]}) begin
        if (flag) begin
          state_o.count = grown;
        end
      end else begin
        state_o.count = '0;
        state_o.flag  = 1'b0;
      end
    end else if (!gamepak) begin
      if (!(seq && wide)) begin
        state_o.count = '0;
      end
    end else if (!seq) begin
      if (cnt[0]) begin
        if (cnt[1]) begin
          state_o.count = drop2;
          wait_o        = '0;
        end else begin
          state_o.count = drop1;
          wait_o        = (w_s16 == '0) ? '0 : w_s16 - bwspt_pkg::WAIT_W'(1);
        end
      end else begin
        state_o.count = '0;
      end
    end else if (!wide) begin
      if (cnt[0]) begin
        state_o.count = drop1;
        wait_o        = '0;
      end else if (cnt > bwspt_pkg::LOW_BYTE_MAX) begin
        state_o.count = '0;
        wait_o        = w_ns16;
      end
    end else begin
      if (cnt[0]) begin
        if (cnt[1]) begin
          state_o.count = drop2;
          wait_o        = '0;
        end else begin
          state_o.count = drop1;
          wait_o        = w_s16;
        end
      end else if (cnt > bwspt_pkg::LOW_BYTE_MAX) begin
        state_o.count = '0;
        wait_o        = w_ns32;
      end
    end
  end

endmodule

/* hdl/bus_wait_state_prefetch_timer_unit.sv */
// Top level: bus wait-state and prefetch timer with stream ports and config port.
// Each accepted word is one bus access; the unit returns one word per access with the
// wait states charged and the prefetch flag after it. One access is taken every cycle
// unless the output is stalled. Each access passes through an input register, then the
// table lookup and prefetch count update that feed the output register. The prefetch
// count and flag advance as each access moves into the output register, so
// back-to-back accesses see each other's effects in order. The config port is always
// ready; write it only while no access is in flight.
module bus_wait_state_prefetch_timer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] operation, [34:3] address, [35] prefetch_set, [39:36] zero
  input  logic [bwspt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] wait_cycles, [4] prefetch_active, [7:5] zero
  output logic [bwspt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bwspt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bwspt_pkg::TBL_W-1:0]       cfg_data_i
);

  bwspt_pkg::wait_tbl_t tbl_q;
  bwspt_pkg::pf_state_t state_q, state_d;

  logic                          s1_valid_q;
  logic [bwspt_pkg::OP_W-1:0]    s1_op_q;
  logic [bwspt_pkg::PAGE_W-1:0]  s1_page_q;
  logic                          s1_pset_q;
  logic                          out_valid_q;
  logic [bwspt_pkg::WAIT_W-1:0]  out_wait_q, wait_d;
  logic                          out_act_q;
  logic                          out_en, s1_adv, in_fire;

  assign cfg_ready_o   = 1'b1;
  assign out_en        = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_en;
  assign s_axis_tready = !s1_valid_q || out_en;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bwspt_pkg::REG_WAIT_NONSEQ16: tbl_q.nonseq16 <= cfg_data_i;
        bwspt_pkg::REG_WAIT_NONSEQ32: tbl_q.nonseq32 <= cfg_data_i;
        bwspt_pkg::REG_WAIT_SEQ16:    tbl_q.seq16    <= cfg_data_i;
        bwspt_pkg::REG_WAIT_SEQ32:    tbl_q.seq32    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= s_axis_tdata[bwspt_pkg::OP_W-1:0];
      s1_page_q <= s_axis_tdata[bwspt_pkg::OP_W+bwspt_pkg::PAGE_LSB +: bwspt_pkg::PAGE_W];
      s1_pset_q <= s_axis_tdata[bwspt_pkg::OP_W+bwspt_pkg::ADDR_W];
    end
    if (s1_adv) begin
      out_wait_q <= wait_d;
      out_act_q  <= state_d.flag;
    end
  end

  bwspt_step u_step (
    .op_i    (s1_op_q),
    .page_i  (s1_page_q),
    .pset_i  (s1_pset_q),
    .tbl_i   (tbl_q),
    .state_i (state_q),
    .state_o (state_d),
    .wait_o  (wait_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_act_q, out_wait_q};

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> ($stable(state_q.count) && $stable(state_q.flag)))
    else $error("prefetch state changed without an access");

  a_data_other_page_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_op_q[bwspt_pkg::OP_CODE_BIT] &&
     (s1_page_q < bwspt_pkg::PF_PAGE_LO || s1_page_q > bwspt_pkg::PF_PAGE_HI))
    |=> (!state_q.flag && state_q.count == '0))
    else $error("data access outside prefetch pages left the buffer set");

  a_code_keeps_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_op_q[bwspt_pkg::OP_CODE_BIT] && !s1_pset_q)
    |=> (state_q.flag == $past(state_q.flag)))
    else $error("code access changed the prefetch flag");

endmodule
